// ===== design/tga_byte_stream_decoder_unit_assert.svh =====
`ifndef TGA_BYTE_STREAM_DECODER_UNIT_ASSERT_SVH
`define TGA_BYTE_STREAM_DECODER_UNIT_ASSERT_SVH

// Both macros sample on clk_i and are disabled while rst_ni is low.
`define TGADEC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define TGADEC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/tgadec_pkg.sv =====
package tgadec_pkg;

  localparam int unsigned PaletteEntriesDef = 256;
  localparam int unsigned LenW = 9;

  localparam logic [31:0] OpaqueBlack = 32'hFF00_0000;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_INFO    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_IMG_TYPE    = 3'd0,
    ERR_MAP_ORIGIN  = 3'd1,
    ERR_MAP_DEPTH   = 3'd2,
    ERR_PIXEL_DEPTH = 3'd3,
    ERR_MAP_LENGTH  = 3'd4
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] column;
    logic [15:0] row;
    logic [31:0] value;
    logic [15:0] width;
    logic [15:0] height;
    logic [5:0]  bpp;
    err_e        err;
    logic        last;
    logic        pal_read;
    logic        pal_hit;
  } result_t;

endpackage

// ===== design/tgadec_ram.sv =====
module tgadec_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tgadec_parser.sv =====
`include "tga_byte_stream_decoder_unit_assert.svh"

module tgadec_parser #(
  parameter int unsigned PALETTE_ENTRIES = tgadec_pkg::PaletteEntriesDef,
  localparam int unsigned AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                func_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  input  logic [7:0]          palette_index_i,
  output logic                res_valid_o,
  output tgadec_pkg::result_t res_o,
  output logic                ram_we_o,
  output logic [AW-1:0]       ram_waddr_o,
  output logic [31:0]         ram_wdata_o
);

  localparam int unsigned LenW = tgadec_pkg::LenW;
  localparam logic [LenW-1:0] PalLimit = LenW'(PALETTE_ENTRIES);

  localparam logic [4:0] HdrIdLen    = 5'd0;
  localparam logic [4:0] HdrMapType  = 5'd1;
  localparam logic [4:0] HdrImgType  = 5'd2;
  localparam logic [4:0] HdrOrgLo    = 5'd3;
  localparam logic [4:0] HdrOrgHi    = 5'd4;
  localparam logic [4:0] HdrLenLo    = 5'd5;
  localparam logic [4:0] HdrLenHi    = 5'd6;
  localparam logic [4:0] HdrMapDepth = 5'd7;
  localparam logic [4:0] HdrWidthLo  = 5'd12;
  localparam logic [4:0] HdrWidthHi  = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrPxDepth  = 5'd16;
  localparam logic [4:0] HdrDesc     = 5'd17;

  localparam logic [7:0] ImgTypeMapped = 8'd1;
  localparam logic [7:0] ImgTypeTrue   = 8'd2;
  localparam logic [7:0] Depth24       = 8'd24;
  localparam logic [7:0] Depth32       = 8'd32;
  localparam logic [15:0] SmallMap     = 16'd16;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_IDSKIP  = 6'b000100,
    PH_PALETTE = 6'b001000,
    PH_PIXELS  = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_e;

  function automatic phase_e start_phase(logic [15:0] w, logic [15:0] h);
    return ((w == '0) || (h == '0)) ? PH_DONE : PH_PIXELS;
  endfunction

  function automatic phase_e after_id_phase(logic has, logic [LenW-1:0] len,
                                            logic [15:0] w, logic [15:0] h);
    if (has && (len != '0)) begin
      return PH_PALETTE;
    end
    return start_phase(w, h);
  endfunction

  phase_e            phase_q, phase_d;
  logic [4:0]        header_count_q, header_count_d;
  logic [7:0]        id_skip_q, id_skip_d;
  logic              has_palette_q, has_palette_d;
  logic [LenW-1:0]   palette_length_q, palette_length_d;
  logic              pal_alpha_q, pal_alpha_d;
  logic              tc_alpha_q, tc_alpha_d;
  logic [63:0]       scratch_q, scratch_d;
  logic [15:0]       width_q, width_d;
  logic [15:0]       height_q, height_d;
  logic              top_down_q, top_down_d;
  logic [LenW-1:0]   entry_index_q, entry_index_d;
  logic [1:0]        bie_q, bie_d;
  logic [23:0]       partial_q, partial_d;
  logic [15:0]       column_q, column_d;
  logic [15:0]       row_q, row_d;

  logic [LenW-1:0]   loaded;
  logic [23:0]       partial_new;
  logic              alpha_sel;
  logic              complete;
  logic [7:0]        alpha_byte;
  logic              do_put;
  logic [31:0]       pix_val;
  logic              info_ok;
  logic [5:0]        info_bpp;

  logic [7:0]  hdr_map_type;
  logic [7:0]  hdr_img_type;
  logic [15:0] hdr_origin;
  logic [15:0] hdr_length;
  logic [7:0]  hdr_map_depth;
  logic [7:0]  hdr_px_depth;

  assign hdr_map_type  = scratch_q[7:0];
  assign hdr_img_type  = scratch_q[15:8];
  assign hdr_origin    = scratch_q[31:16];
  assign hdr_length    = scratch_q[47:32];
  assign hdr_map_depth = scratch_q[55:48];
  assign hdr_px_depth  = scratch_q[63:56];

  always_comb begin
    case (phase_q)
      PH_PALETTE: loaded = entry_index_q;
      PH_PIXELS,
      PH_DONE:    loaded = palette_length_q;
      default:    loaded = '0;
    endcase
  end

  always_comb begin
    phase_d          = phase_q;
    header_count_d   = header_count_q;
    id_skip_d        = id_skip_q;
    has_palette_d    = has_palette_q;
    palette_length_d = palette_length_q;
    pal_alpha_d      = pal_alpha_q;
    tc_alpha_d       = tc_alpha_q;
    scratch_d        = scratch_q;
    width_d          = width_q;
    height_d         = height_q;
    top_down_d       = top_down_q;
    entry_index_d    = entry_index_q;
    bie_d            = bie_q;
    partial_d        = partial_q;
    column_d         = column_q;
    row_d            = row_q;

    res_valid_o = 1'b0;
    res_o       = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    partial_new = '0;
    alpha_sel   = 1'b0;
    complete    = 1'b0;
    alpha_byte  = 8'hFF;
    do_put      = 1'b0;
    pix_val     = '0;
    info_ok     = 1'b0;
    info_bpp    = '0;

    if (accept_i && func_i) begin
      res_valid_o    = 1'b1;
      res_o.kind     = tgadec_pkg::KIND_PALETTE;
      res_o.pal_read = 1'b1;
      res_o.pal_hit  = ({1'b0, palette_index_i} < loaded) &&
                       ({1'b0, palette_index_i} < PalLimit);
    end else if (accept_i) begin
      if (first_byte_i) begin
        phase_d          = PH_HEADER;
        header_count_d   = '0;
        id_skip_d        = '0;
        has_palette_d    = 1'b0;
        palette_length_d = '0;
        pal_alpha_d      = 1'b0;
        tc_alpha_d       = 1'b0;
        scratch_d        = '0;
        width_d          = '0;
        height_d         = '0;
        top_down_d       = 1'b0;
        entry_index_d    = '0;
        bie_d            = '0;
        partial_d        = '0;
        column_d         = '0;
        row_d            = '0;
      end

      alpha_sel   = (phase_d == PH_PALETTE) ? pal_alpha_d : tc_alpha_d;
      partial_new = partial_d;
      case (bie_d)
        2'd0:    partial_new[23:16] = data_byte_i;
        2'd1:    partial_new[15:8]  = data_byte_i;
        2'd2:    partial_new[7:0]   = data_byte_i;
        default: partial_new        = partial_d;
      endcase
      complete   = alpha_sel ? (bie_d == 2'd3) : (bie_d == 2'd2);
      alpha_byte = alpha_sel ? data_byte_i : 8'hFF;

      case (phase_d)
        PH_HEADER: begin
          header_count_d = header_count_d + 5'd1;
          case (header_count_q & {5{~first_byte_i}})
            HdrIdLen:    id_skip_d          = data_byte_i;
            HdrMapType:  scratch_d[7:0]     = data_byte_i;
            HdrImgType:  scratch_d[15:8]    = data_byte_i;
            HdrOrgLo:    scratch_d[23:16]   = data_byte_i;
            HdrOrgHi:    scratch_d[31:24]   = data_byte_i;
            HdrLenLo:    scratch_d[39:32]   = data_byte_i;
            HdrLenHi:    scratch_d[47:40]   = data_byte_i;
            HdrMapDepth: scratch_d[55:48]   = data_byte_i;
            HdrWidthLo:  width_d[7:0]       = data_byte_i;
            HdrWidthHi:  width_d[15:8]      = data_byte_i;
            HdrHeightLo: height_d[7:0]      = data_byte_i;
            HdrHeightHi: height_d[15:8]     = data_byte_i;
            HdrPxDepth:  scratch_d[63:56]   = data_byte_i;
            HdrDesc: begin
              top_down_d  = data_byte_i[5];
              phase_d     = PH_DONE;
              res_valid_o = 1'b1;
              res_o.kind  = tgadec_pkg::KIND_ERROR;
              if ((hdr_img_type != ImgTypeMapped) && (hdr_img_type != ImgTypeTrue)) begin
                res_o.err = tgadec_pkg::ERR_IMG_TYPE;
              end else if (hdr_map_type != '0) begin
                if (hdr_origin != '0) begin
                  res_o.err = tgadec_pkg::ERR_MAP_ORIGIN;
                end else if ((hdr_map_depth != Depth24) && (hdr_map_depth != Depth32)) begin
                  res_o.err = tgadec_pkg::ERR_MAP_DEPTH;
                end else if (hdr_length > 16'(PALETTE_ENTRIES)) begin
                  res_o.err = tgadec_pkg::ERR_MAP_LENGTH;
                end else begin
                  has_palette_d    = 1'b1;
                  palette_length_d = hdr_length[LenW-1:0];
                  pal_alpha_d      = (hdr_map_depth == Depth32);
                  info_bpp         = (hdr_length <= SmallMap) ? 6'd4 : 6'd8;
                  info_ok          = 1'b1;
                end
              end else if ((hdr_px_depth != Depth24) && (hdr_px_depth != Depth32)) begin
                res_o.err = tgadec_pkg::ERR_PIXEL_DEPTH;
              end else begin
                tc_alpha_d = (hdr_px_depth == Depth32);
                info_bpp   = 6'd32;
                info_ok    = 1'b1;
              end
              if (info_ok) begin
                res_o.kind   = tgadec_pkg::KIND_INFO;
                res_o.width  = width_d;
                res_o.height = height_d;
                res_o.bpp    = info_bpp;
                if (id_skip_d != '0) begin
                  phase_d = PH_IDSKIP;
                end else begin
                  phase_d = after_id_phase(has_palette_d, palette_length_d, width_d,
                                           height_d);
                end
              end
            end
            default: scratch_d = scratch_d;
          endcase
        end
        PH_IDSKIP: begin
          if (id_skip_d != '0) begin
            id_skip_d = id_skip_d - 8'd1;
          end
          if (id_skip_d == '0) begin
            phase_d = after_id_phase(has_palette_d, palette_length_d, width_d, height_d);
          end
        end
        PH_PALETTE: begin
          if (complete) begin
            ram_we_o      = (entry_index_d < PalLimit);
            ram_waddr_o   = entry_index_d[AW-1:0];
            ram_wdata_o   = {alpha_byte, partial_new};
            entry_index_d = entry_index_d + LenW'(1);
            bie_d         = '0;
            partial_d     = '0;
            if (entry_index_d >= palette_length_d) begin
              phase_d = start_phase(width_d, height_d);
            end
          end else begin
            bie_d     = bie_d + 2'd1;
            partial_d = partial_new;
          end
        end
        PH_PIXELS: begin
          if (has_palette_d) begin
            do_put  = 1'b1;
            pix_val = {24'd0, data_byte_i};
          end else if (complete) begin
            do_put    = 1'b1;
            pix_val   = {alpha_byte, partial_new};
            bie_d     = '0;
            partial_d = '0;
          end else begin
            bie_d     = bie_d + 2'd1;
            partial_d = partial_new;
          end
        end
        default: phase_d = phase_d;
      endcase

      if (do_put) begin
        res_valid_o  = 1'b1;
        res_o.kind   = tgadec_pkg::KIND_PIXEL;
        res_o.column = column_d;
        res_o.row    = top_down_d ? row_d : (height_d - 16'd1 - row_d);
        res_o.value  = pix_val;
        if (({1'b0, column_d} + 17'd1) >= {1'b0, width_d}) begin
          column_d = '0;
          if (({1'b0, row_d} + 17'd1) >= {1'b0, height_d}) begin
            res_o.last = 1'b1;
            phase_d    = PH_DONE;
          end else begin
            row_d = row_d + 16'd1;
          end
        end else begin
          column_d = column_d + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_IDLE;
      header_count_q   <= '0;
      id_skip_q        <= '0;
      has_palette_q    <= 1'b0;
      palette_length_q <= '0;
      pal_alpha_q      <= 1'b0;
      tc_alpha_q       <= 1'b0;
      scratch_q        <= '0;
      width_q          <= '0;
      height_q         <= '0;
      top_down_q       <= 1'b0;
      entry_index_q    <= '0;
      bie_q            <= '0;
      partial_q        <= '0;
      column_q         <= '0;
      row_q            <= '0;
    end else begin
      phase_q          <= phase_d;
      header_count_q   <= header_count_d;
      id_skip_q        <= id_skip_d;
      has_palette_q    <= has_palette_d;
      palette_length_q <= palette_length_d;
      pal_alpha_q      <= pal_alpha_d;
      tc_alpha_q       <= tc_alpha_d;
      scratch_q        <= scratch_d;
      width_q          <= width_d;
      height_q         <= height_d;
      top_down_q       <= top_down_d;
      entry_index_q    <= entry_index_d;
      bie_q            <= bie_d;
      partial_q        <= partial_d;
      column_q         <= column_d;
      row_q            <= row_d;
    end
  end

  `TGADEC_ASSERT(a_pal_fill_bound, (phase_q != PH_PALETTE) || (entry_index_q < palette_length_q), "palette fill ran past its length")
  `TGADEC_ASSERT(a_pixels_nonempty, (phase_q != PH_PIXELS) || ((width_q != '0) && (height_q != '0)), "pixel phase entered for an empty image")
  `TGADEC_ASSERT(a_idskip_nonzero, (phase_q != PH_IDSKIP) || (id_skip_q != '0), "ID skip phase with nothing left to skip")

endmodule

// ===== design/tgadec_out.sv =====
`include "tga_byte_stream_decoder_unit_assert.svh"

module tgadec_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                res_valid_i,
  input  tgadec_pkg::result_t res_i,
  input  logic [31:0]         rdata_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output tgadec_pkg::result_t out_res_o
);

  logic                s1_valid_q, s1_valid_d;
  tgadec_pkg::result_t s1_q, s1_d;
  logic                s2_valid_q, s2_valid_d;
  tgadec_pkg::result_t s2_q, s2_d;
  logic                adv;
  logic                load;

  assign adv        = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign load       = accept_i && res_valid_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    s2_valid_d = s2_valid_q;
    s2_d       = s2_q;
    if (adv) begin
      s1_valid_d = 1'b0;
      s2_valid_d = 1'b1;
      s2_d       = s1_q;
      if (s1_q.pal_read) begin
        s2_d.value = s1_q.pal_hit ? rdata_i : tgadec_pkg::OpaqueBlack;
      end
    end else if (out_ready_i) begin
      s2_valid_d = 1'b0;
    end
    if (load) begin
      s1_valid_d = 1'b1;
      s1_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_res_o   = s2_q;

  `TGADEC_ASSERT_NEXT(a_s1_moves, s1_valid_q && (!s2_valid_q || out_ready_i), s2_valid_q, "read stage item failed to reach the output register")
  `TGADEC_ASSERT_NEXT(a_s1_holds, s1_valid_q && s2_valid_q && !out_ready_i, s1_valid_q && $stable(s1_q), "stalled read stage item changed")

endmodule

// ===== design/tga_byte_stream_decoder_unit.sv =====
// Decodes an uncompressed TGA file presented one byte per item (func 0) and
// answers palette lookups (func 1). One item is taken every cycle unless the
// read stage holds a stalled result. A result passes through the palette RAM
// read stage and the output register; items keep flowing while a result waits
// to be taken, until a second result fills the read stage. The palette lives
// in one single-port-write RAM with a registered read of PALETTE_ENTRIES
// words, which also sets the largest palette accepted; entries not loaded for
// the current file read as opaque black and the RAM needs no clearing after reset.
module tga_byte_stream_decoder_unit #(
  parameter int unsigned PALETTE_ENTRIES = tgadec_pkg::PaletteEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [7:0]  palette_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] column_o,
  output logic [15:0] row_o,
  output logic [31:0] pixel_value_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [5:0]  bits_per_pixel_o,
  output logic [2:0]  error_code_o,
  output logic        last_pixel_o
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  logic                accept;
  logic                res_valid;
  tgadec_pkg::result_t res;
  tgadec_pkg::result_t out_res;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_wdata;
  logic [31:0]         ram_rdata;

  assign accept = in_valid_i && in_ready_o;

  tgadec_parser #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .palette_index_i(palette_index_i),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata)
  );

  tgadec_ram #(
    .Width(32),
    .Depth(PALETTE_ENTRIES)
  ) u_palette_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept && func_i),
    .raddr_i(palette_index_i[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  tgadec_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .res_valid_i(res_valid),
    .res_i      (res),
    .rdata_i    (ram_rdata),
    .out_ready_i(out_ready_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_res_o  (out_res)
  );

  assign kind_o           = out_res.kind;
  assign column_o         = out_res.column;
  assign row_o            = out_res.row;
  assign pixel_value_o    = out_res.value;
  assign image_width_o    = out_res.width;
  assign image_height_o   = out_res.height;
  assign bits_per_pixel_o = out_res.bpp;
  assign error_code_o     = out_res.err;
  assign last_pixel_o     = out_res.last;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_IDSKIP,
    ST_PALETTE,
    ST_PIXELS,
    ST_DONE
  } dec_phase_e;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic       first;
    logic [7:0] pidx;
  } tga_item_t;

  typedef struct packed {
    tgadec_pkg::kind_e kind;
    logic [15:0]       column;
    logic [15:0]       row;
    logic [31:0]       value;
    logic [15:0]       width;
    logic [15:0]       height;
    logic [5:0]        bpp;
    tgadec_pkg::err_e  err;
    logic              last;
  } tga_result_t;

  localparam int HoldStart = 1200;
  localparam int HoldLen   = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        first_byte_i = 1'b0;
  logic [7:0]  palette_index_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [15:0] column_o;
  logic [15:0] row_o;
  logic [31:0] pixel_value_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic [5:0]  bits_per_pixel_o;
  logic [2:0]  error_code_o;
  logic        last_pixel_o;

  tga_byte_stream_decoder_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .palette_index_i  (palette_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .column_o         (column_o),
    .row_o            (row_o),
    .pixel_value_o    (pixel_value_o),
    .image_width_o    (image_width_o),
    .image_height_o   (image_height_o),
    .bits_per_pixel_o (bits_per_pixel_o),
    .error_code_o     (error_code_o),
    .last_pixel_o     (last_pixel_o)
  );

  tga_item_t   to_send[$];
  tga_result_t results_due[$];
  int          mismatches = 0;
  bit          all_sent = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_cycle;

  dec_phase_e  ph = ST_IDLE;
  logic [4:0]  hdr_cnt = '0;
  logic [7:0]  id_left = '0;
  logic        has_pal = 1'b0;
  logic [8:0]  pal_len = '0;
  logic        pal_alpha = 1'b0;
  logic        tc_alpha = 1'b0;
  logic [63:0] scratch = '0;
  logic [15:0] wid = '0;
  logic [15:0] hgt = '0;
  logic        top_down = 1'b0;
  logic [8:0]  ent_idx = '0;
  int          byte_in = 0;
  logic [23:0] col_partial = '0;
  logic [15:0] col_cnt = '0;
  logic [15:0] row_cnt = '0;
  logic [31:0] pal_mem [tgadec_pkg::PaletteEntriesDef];

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void start_pixels();
    col_cnt = '0;
    row_cnt = '0;
    byte_in = 0;
    col_partial = '0;
    ph = (wid == 16'd0 || hgt == 16'd0) ? ST_DONE : ST_PIXELS;
  endfunction

  function automatic void leave_id_field();
    if (has_pal && pal_len != 9'd0) begin
      ph = ST_PALETTE;
      ent_idx = '0;
      byte_in = 0;
      col_partial = '0;
    end else begin
      start_pixels();
    end
  endfunction

  // Collects B, G, R and optional A bytes; returns 1 with the RGBA word when complete.
  function automatic logic gather_bgra(logic [7:0] b, logic with_alpha,
                                       output logic [31:0] colour);
    colour = '0;
    if (byte_in < 3) begin
      col_partial[23 - 8 * byte_in -: 8] = b;
      byte_in++;
    end else begin
      byte_in = 4;
    end
    if (byte_in >= (with_alpha ? 4 : 3)) begin
      colour = {(with_alpha ? b : 8'hFF), col_partial};
      byte_in = 0;
      col_partial = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void emit_pixel(logic [31:0] v);
    tga_result_t r;
    r = '0;
    r.kind = tgadec_pkg::KIND_PIXEL;
    r.column = col_cnt;
    r.row = top_down ? row_cnt : hgt - 16'd1 - row_cnt;
    r.value = v;
    if ({16'd0, col_cnt} + 32'd1 >= {16'd0, wid}) begin
      col_cnt = '0;
      if ({16'd0, row_cnt} + 32'd1 >= {16'd0, hgt}) begin
        r.last = 1'b1;
        ph = ST_DONE;
      end else begin
        row_cnt = row_cnt + 16'd1;
      end
    end else begin
      col_cnt = col_cnt + 16'd1;
    end
    results_due.push_back(r);
  endfunction

  function automatic void decode_item(logic f, logic [7:0] b, logic first, logic [7:0] pidx);
    tga_result_t r;
    logic [31:0] colour;
    logic [8:0]  loaded;
    logic [7:0]  cmap_type, img_type, cmap_depth, px_depth;
    logic [15:0] origin, cmap_len;
    logic        done;
    int          c;
    r = '0;
    if (f) begin
      loaded = (ph == ST_PALETTE) ? ent_idx :
               (ph == ST_PIXELS || ph == ST_DONE) ? pal_len : 9'd0;
      r.kind = tgadec_pkg::KIND_PALETTE;
      r.value = ({1'b0, pidx} < loaded) ? pal_mem[pidx] : tgadec_pkg::OpaqueBlack;
      results_due.push_back(r);
      return;
    end
    if (first) begin
      ph = ST_HEADER;
      hdr_cnt = '0;
      id_left = '0;
      has_pal = 1'b0;
      pal_len = '0;
      pal_alpha = 1'b0;
      tc_alpha = 1'b0;
      scratch = '0;
      wid = '0;
      hgt = '0;
      top_down = 1'b0;
      ent_idx = '0;
      byte_in = 0;
      col_partial = '0;
      col_cnt = '0;
      row_cnt = '0;
    end
    case (ph)
      ST_HEADER: begin
        c = int'(hdr_cnt);
        hdr_cnt = hdr_cnt + 5'd1;
        if (c == 0) id_left = b;
        else if (c <= 7) scratch[8 * (c - 1) +: 8] = b;
        else if (c == 12) wid[7:0] = b;
        else if (c == 13) wid[15:8] = b;
        else if (c == 14) hgt[7:0] = b;
        else if (c == 15) hgt[15:8] = b;
        else if (c == 16) scratch[63:56] = b;
        else if (c == 17) begin
          cmap_type = scratch[7:0];
          img_type = scratch[15:8];
          origin = scratch[31:16];
          cmap_len = scratch[47:32];
          cmap_depth = scratch[55:48];
          px_depth = scratch[63:56];
          top_down = b[5];
          ph = ST_DONE;
          r.kind = tgadec_pkg::KIND_ERROR;
          if (img_type != 8'd1 && img_type != 8'd2) begin
            r.err = tgadec_pkg::ERR_IMG_TYPE;
          end else if (cmap_type != 8'd0 && origin != 16'd0) begin
            r.err = tgadec_pkg::ERR_MAP_ORIGIN;
          end else if (cmap_type != 8'd0 && cmap_depth != 8'd24 && cmap_depth != 8'd32) begin
            r.err = tgadec_pkg::ERR_MAP_DEPTH;
          end else if (cmap_type != 8'd0 &&
                       cmap_len > 16'(tgadec_pkg::PaletteEntriesDef)) begin
            r.err = tgadec_pkg::ERR_MAP_LENGTH;
          end else if (cmap_type == 8'd0 && px_depth != 8'd24 && px_depth != 8'd32) begin
            r.err = tgadec_pkg::ERR_PIXEL_DEPTH;
          end else begin
            r.kind = tgadec_pkg::KIND_INFO;
            r.width = wid;
            r.height = hgt;
            if (cmap_type != 8'd0) begin
              has_pal = 1'b1;
              pal_len = cmap_len[8:0];
              pal_alpha = (cmap_depth == 8'd32);
              r.bpp = (cmap_len <= 16'd16) ? 6'd4 : 6'd8;
            end else begin
              tc_alpha = (px_depth == 8'd32);
              r.bpp = 6'd32;
            end
            if (id_left != 8'd0) ph = ST_IDSKIP;
            else leave_id_field();
          end
          results_due.push_back(r);
        end
      end
      ST_IDSKIP: begin
        if (id_left != 8'd0) id_left = id_left - 8'd1;
        if (id_left == 8'd0) leave_id_field();
      end
      ST_PALETTE: begin
        done = gather_bgra(b, pal_alpha, colour);
        if (done) begin
          pal_mem[ent_idx[7:0]] = colour;
          ent_idx = ent_idx + 9'd1;
          if (ent_idx >= pal_len) start_pixels();
        end
      end
      ST_PIXELS: begin
        if (has_pal) begin
          emit_pixel({24'd0, b});
        end else begin
          done = gather_bgra(b, tc_alpha, colour);
          if (done) emit_pixel(colour);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic add_byte(logic [7:0] b, logic first);
    tga_item_t it;
    it.func = 1'b0;
    it.data = b;
    it.first = first;
    it.pidx = 8'($urandom_range(0, 255));
    to_send.push_back(it);
  endtask

  task automatic add_lookup(logic [7:0] idx);
    tga_item_t it;
    it.func = 1'b1;
    it.data = 8'($urandom_range(0, 255));
    it.first = 1'($urandom_range(0, 1));
    it.pidx = idx;
    to_send.push_back(it);
  endtask

  // Header, ID field, palette and pixel data of one file; a keep >= 0 shorter than the file cuts it short.
  task automatic add_file(int id_len, int cmap_type, int img_type, int origin, int cmap_len,
                          int cmap_depth, int wid_px, int hgt_px, int px_depth, int desc,
                          int keep, int lookup_pct);
    logic [7:0] hdr [18];
    logic [7:0] b;
    longint     body;
    int         total;
    int         n;
    bit         ok;
    hdr[0] = id_len[7:0];
    hdr[1] = cmap_type[7:0];
    hdr[2] = img_type[7:0];
    hdr[3] = origin[7:0];
    hdr[4] = origin[15:8];
    hdr[5] = cmap_len[7:0];
    hdr[6] = cmap_len[15:8];
    hdr[7] = cmap_depth[7:0];
    for (n = 8; n < 12; n++) hdr[n] = 8'($urandom_range(0, 255));
    hdr[12] = wid_px[7:0];
    hdr[13] = wid_px[15:8];
    hdr[14] = hgt_px[7:0];
    hdr[15] = hgt_px[15:8];
    hdr[16] = px_depth[7:0];
    hdr[17] = desc[7:0];
    ok = (img_type == 1 || img_type == 2) &&
         ((cmap_type != 0) ? (origin == 0 && (cmap_depth == 24 || cmap_depth == 32) &&
                              cmap_len <= 256)
                           : (px_depth == 24 || px_depth == 32));
    body = 0;
    if (ok) begin
      if (cmap_type != 0)
        body = id_len + cmap_len * (cmap_depth / 8) + longint'(wid_px) * hgt_px;
      else
        body = id_len + longint'(wid_px) * hgt_px * (px_depth / 8);
    end
    if (keep >= 0 && keep < 18 + body) total = keep;
    else total = 18 + int'(body);
    for (n = 0; n < total; n++) begin
      if (n < 18) b = hdr[n];
      else b = 8'($urandom_range(0, 255));
      add_byte(b, n == 0);
      if ($urandom_range(0, 99) < lookup_pct) begin
        if ($urandom_range(0, 1) == 0) add_lookup(8'($urandom_range(0, 255)));
        else add_lookup(8'($urandom_range(0, (cmap_len > 250) ? 255 : cmap_len + 2)));
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 100) $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tga_item_t nxt;
    logic      offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_item(func_i, data_byte_i, first_byte_i, palette_index_i);
      end
      if (!in_valid_i || in_ready_o) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (to_send.size() == 0) begin
          all_sent = 1'b1;
        end else begin
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          nxt = to_send.pop_front();
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        in_valid_i <= offer;
        if (offer) begin
          func_i <= nxt.func;
          data_byte_i <= nxt.data;
          first_byte_i <= nxt.first;
          palette_index_i <= nxt.pidx;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_cycle <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen) begin
        out_ready_i <= 1'b0;
      end else begin
        case ((rx_cycle / 300) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 7) != 0);
          default: out_ready_i <= ((rx_cycle % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    tga_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        if (mismatches < 100) $error("unexpected item: kind %0d", kind_o);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("column", 32'(want.column), 32'(column_o));
        check_field("row", 32'(want.row), 32'(row_o));
        check_field("pixel_value", want.value, pixel_value_o);
        check_field("image_width", 32'(want.width), 32'(image_width_o));
        check_field("image_height", 32'(want.height), 32'(image_height_o));
        check_field("bits_per_pixel", 32'(want.bpp), 32'(bits_per_pixel_o));
        check_field("error_code", 32'(want.err), 32'(error_code_o));
        check_field("last_pixel", 32'(want.last), 32'(last_pixel_o));
      end
    end
  end

  initial begin
    int file_no;
    int id_len, cmap_type, img_type, origin, cmap_len, cmap_depth;
    int wid_px, hgt_px, px_depth, keep, sel;
    add_lookup(8'd0);
    add_lookup(8'd255);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_file(0, 0, 2, 0, 0, 0, 1, 1, 24, 32'h20, -1, 0);
    file_no = 0;
    while (to_send.size() < 1950) begin
      file_no++;
      id_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      cmap_type = ($urandom_range(0, 1) == 0) ? 0 :
                  (($urandom_range(0, 3) == 0) ? $urandom_range(2, 255) : 1);
      img_type = $urandom_range(1, 2);
      origin = 0;
      cmap_len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
      cmap_depth = ($urandom_range(0, 1) == 0) ? 24 : 32;
      if (cmap_type != 0) px_depth = $urandom_range(0, 255);
      else px_depth = ($urandom_range(0, 1) == 0) ? 24 : 32;
      wid_px = $urandom_range(0, 5);
      hgt_px = $urandom_range(0, 4);
      keep = -1;
      sel = $urandom_range(0, 99);
      if (file_no == 8) begin
        cmap_type = 1;
        cmap_len = 256;
        cmap_depth = 24;
        wid_px = 2;
        hgt_px = 2;
      end else if (sel < 15) begin
        case ($urandom_range(0, 4))
          0: img_type = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(3, 255);
          1: begin
            if (cmap_type == 0) cmap_type = 1;
            origin = $urandom_range(1, 65535);
          end
          2: begin
            if (cmap_type == 0) cmap_type = 1;
            cmap_depth = $urandom_range(0, 255);
            if (cmap_depth == 24 || cmap_depth == 32) cmap_depth++;
          end
          3: begin
            cmap_type = 0;
            px_depth = $urandom_range(0, 255);
            if (px_depth == 24 || px_depth == 32) px_depth++;
          end
          default: begin
            if (cmap_type == 0) cmap_type = 1;
            cmap_len = $urandom_range(257, 65535);
          end
        endcase
      end else if (sel < 23) begin
        id_len = $urandom_range(0, 255);
        wid_px = $urandom_range(0, 65535);
        hgt_px = $urandom_range(0, 65535);
        keep = 18 + $urandom_range(0, 40);
      end else if (sel < 32) begin
        keep = $urandom_range(1, 60);
      end
      add_file(id_len, cmap_type, img_type, origin, cmap_len, cmap_depth, wid_px, hgt_px,
               px_depth, $urandom_range(0, 255), keep, 8);
      if (file_no == 8) begin
        add_lookup(8'd255);
        add_lookup(8'd0);
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!all_sent || results_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
